// ===== hw/rtl/bpsuf_pkg.sv =====
`timescale 1ns / 1ps

package bpsuf_pkg;

    localparam int CMD_BITS   = 2;
    localparam int ID_BITS    = 10;
    localparam int VALUE_BITS = 20;
    localparam int COUNT_BITS = 11;
    localparam int SUM_BITS   = 63;
    localparam int ACC_BITS   = 64;

    localparam logic [CMD_BITS-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_EDGE   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_START  = 2'd2;

    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 11'd1;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [ID_BITS-1:0]    node_id;
        logic [VALUE_BITS-1:0] node_value;
        logic [ID_BITS-1:0]    other_end;
    } in_item_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] pair_sum;
        logic                edge_overflow;
    } result_t;

    typedef struct packed {
        logic [ID_BITS-1:0] a;
        logic [ID_BITS-1:0] b;
    } edge_t;

endpackage

// ===== hw/rtl/bpsuf_mul.sv =====
`timescale 1ns / 1ps

module bpsuf_mul #(
    parameter int A_BITS = 31,
    parameter int B_BITS = 11
) (
    input  logic                     clk,
    input  logic [A_BITS-1:0]        a,
    input  logic [B_BITS-1:0]        b,
    output logic [A_BITS+B_BITS-1:0] prod_reg
);

    logic [A_BITS+B_BITS-1:0] prod_next;

    assign prod_next = (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== hw/rtl/bottleneck_pair_sum_union_find.sv =====
`timescale 1ns / 1ps

// Maximum-bottleneck all-pairs sum over a node-weighted undirected graph.
//
// Command channel: an item beat is taken when start is high and busy is low.
// Weight loads (cmd 0) and edge loads (cmd 1) do not change state, so busy
// stays low and loads stream one per cycle. A start beat (cmd 2) raises busy
// for the whole computation, then done pulses for exactly one cycle with the
// result beat; the receiver cannot stall it, so it must take it then.
// node_count (cfg_we/cfg_wdata) must be written only while no start is running; not enforced.
//
// Sequence of a start, with n nodes and E loaded edges: union-find init over
// the n nodes, then, node by node in order of falling weight, a weight sweep
// over the nodes that selects the next node and an edge sweep over the loaded
// edges; for every incident edge to an already active neighbor come the root
// walks (link reads along the path to the root) and a merge through the shared
// multiplier. The node-selection sweep over the weight memory and the edge sweep dominate the run time.
//
// Reset clears the edge count, the overflow flag and sets node_count to 1.
// Weights and edges are kept across starts, so a repeated start recomputes.
module bottleneck_pair_sum_union_find #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  bpsuf_pkg::in_item_t                   item,
    output logic                                  busy,
    output logic                                  done,
    output bpsuf_pkg::result_t                    result,
    input  logic                                  cfg_we,
    input  logic [bpsuf_pkg::COUNT_BITS-1:0]      cfg_wdata
);

    import bpsuf_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int KW  = WEIGHT_BITS + NW;
    localparam int PA  = WEIGHT_BITS + NCW;
    localparam int PW  = PA + NCW;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SEL_RD, S_SEL_CMP, S_SEL_END, S_EDGE_RD, S_EDGE_CHK,
        S_VW_CHK, S_FU_RD, S_FU_CHK, S_FV_RD, S_FV_CHK, S_SZ_A, S_SZ_B, S_SZ_C,
        S_MUL2
    } state_t;

    // memories
    logic [WEIGHT_BITS-1:0] weight_mem [MAX_NODES];
    edge_t                  edge_mem   [MAX_EDGES];
    logic [NW-1:0]          link_mem   [MAX_NODES];
    logic [NCW-1:0]         size_mem   [MAX_NODES];

    logic [WEIGHT_BITS-1:0] weight_q;
    edge_t                  edge_q;
    logic [NW-1:0]          link_q;
    logic [NCW-1:0]         size_q;

    state_t                 state_reg;
    logic [COUNT_BITS-1:0]  node_count_reg;
    logic [NCW-1:0]         n_reg;
    logic [NCW-1:0]         idx_reg;
    logic [EW-1:0]          k_reg;
    logic [EW-1:0]          edges_loaded_reg;
    logic                   overflow_reg;
    logic                   first_reg;
    logic                   best_found_reg;
    logic [KW-1:0]          best_key_reg;
    logic [KW-1:0]          cur_key_reg;
    logic [NW-1:0]          cur_u_reg;
    logic [NW-1:0]          v_reg;
    logic [NW-1:0]          x_reg;
    logic [NW-1:0]          ru_reg;
    logic [NW-1:0]          rv_reg;
    logic [NCW-1:0]         sa_reg;
    logic [NCW-1:0]         sb_reg;
    logic [ACC_BITS-1:0]    sum_reg;
    logic                   done_reg;
    result_t                result_reg;
    logic                   acc_pending_reg;

    logic                   accept;
    logic [NCW-1:0]         n_next;
    logic [WEIGHT_BITS-1:0] w_addr_val;
    logic [NW-1:0]          w_rd_addr;
    logic [NW-1:0]          link_rd_addr;
    logic [NW-1:0]          size_rd_addr;
    logic                   tbl_we;
    logic [NW-1:0]          tbl_waddr;
    logic [NW-1:0]          link_wdata;
    logic [NCW-1:0]         size_wdata;
    logic [KW-1:0]          cand_key;
    logic                   edge_in_range;
    logic                   edge_hit;
    logic [NW-1:0]          edge_other;
    logic [PA-1:0]          mul_a;
    logic [NCW-1:0]         mul_b;
    logic [PW-1:0]          prod_reg;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // clip node_count to the memory depth
    assign n_next = (32'(node_count_reg) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_reg);

    assign w_addr_val = WEIGHT_BITS'(item.node_value);
    assign cand_key   = {weight_q, ~idx_reg[NW-1:0]};

    assign edge_in_range = (32'(edge_q.a) < 32'(n_reg)) && (32'(edge_q.b) < 32'(n_reg));
    assign edge_other    = (NW'(edge_q.a) == cur_u_reg) ? NW'(edge_q.b) : NW'(edge_q.a);
    assign edge_hit      = edge_in_range && (edge_q.a != edge_q.b) &&
                           ((NW'(edge_q.a) == cur_u_reg) || (NW'(edge_q.b) == cur_u_reg));

    always_comb
    begin
        w_rd_addr    = idx_reg[NW-1:0];
        link_rd_addr = x_reg;
        size_rd_addr = ru_reg;
        tbl_we       = 1'b0;
        tbl_waddr    = idx_reg[NW-1:0];
        link_wdata   = idx_reg[NW-1:0];
        size_wdata   = NCW'(1);
        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_we = 1'b1;
            end
            S_EDGE_CHK:
            begin
                w_rd_addr = edge_other;
            end
            S_SZ_B:
            begin
                size_rd_addr = rv_reg;
            end
            S_SZ_C:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = rv_reg;
                link_wdata = ru_reg;
                size_wdata = NCW'(0);
            end
            S_MUL2:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = ru_reg;
                link_wdata = ru_reg;
                size_wdata = sa_reg + sb_reg;
            end
            default:
            begin
            end
        endcase
    end

    // first pass weight * size_a, second pass that product * size_b
    assign mul_a = (state_reg == S_SZ_C) ? PA'(cur_key_reg[KW-1:NW]) : PA'(prod_reg);
    assign mul_b = (state_reg == S_SZ_C) ? sa_reg : sb_reg;

    bpsuf_mul #(
        .A_BITS (PA),
        .B_BITS (NCW)
    ) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // weight store: written by load beats, read by the sweeps
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_WEIGHT && 32'(item.node_id) < MAX_NODES)
        begin
            weight_mem[NW'(item.node_id)] <= w_addr_val;
        end
        weight_q <= weight_mem[w_rd_addr];
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_EDGE && 32'(edges_loaded_reg) < MAX_EDGES)
        begin
            edge_mem[edges_loaded_reg[EA-1:0]] <= '{a: item.node_id, b: item.other_end};
        end
        edge_q <= edge_mem[k_reg[EA-1:0]];
    end

    // union-find link and set size tables; a root being merged away has its size
    // zeroed and its link pointed at the surviving root, which takes the summed size
    always_ff @(posedge clk)
    begin
        if (tbl_we && !(state_reg == S_MUL2))
        begin
            link_mem[tbl_waddr] <= link_wdata;
        end
        if (tbl_we)
        begin
            size_mem[tbl_waddr] <= size_wdata;
        end
        link_q <= link_mem[link_rd_addr];
        size_q <= size_mem[size_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= NODE_COUNT_RESET;
            edges_loaded_reg <= '0;
            overflow_reg     <= 1'b0;
            done_reg         <= 1'b0;
            n_reg            <= '0;
            idx_reg          <= '0;
            k_reg            <= '0;
            first_reg        <= 1'b1;
            best_found_reg   <= 1'b0;
            best_key_reg     <= '0;
            cur_key_reg      <= '0;
            cur_u_reg        <= '0;
            v_reg            <= '0;
            x_reg            <= '0;
            ru_reg           <= '0;
            rv_reg           <= '0;
            sa_reg           <= '0;
            sb_reg           <= '0;
            sum_reg          <= '0;
            result_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (item.cmd == CMD_EDGE)
                        begin
                            if (32'(edges_loaded_reg) < MAX_EDGES)
                            begin
                                edges_loaded_reg <= edges_loaded_reg + EW'(1);
                            end
                            else
                            begin
                                overflow_reg <= 1'b1;
                            end
                        end
                        else if (item.cmd == CMD_START)
                        begin
                            n_reg          <= n_next;
                            idx_reg        <= '0;
                            sum_reg        <= '0;
                            first_reg      <= 1'b1;
                            best_found_reg <= 1'b0;
                            state_reg      <= (n_next == '0) ? S_SEL_END : S_CLEAR;
                        end
                        else
                        begin
                        end
                    end
                end
                S_CLEAR:
                begin
                    if (idx_reg + NCW'(1) == n_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SEL_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + NCW'(1);
                    end
                end
                S_SEL_RD:
                begin
                    state_reg <= S_SEL_CMP;
                end
                S_SEL_CMP:
                begin
                    // keep the largest key below the last visited node's key
                    if ((first_reg || cand_key < cur_key_reg) &&
                        (!best_found_reg || cand_key > best_key_reg))
                    begin
                        best_found_reg <= 1'b1;
                        best_key_reg   <= cand_key;
                    end
                    idx_reg   <= idx_reg + NCW'(1);
                    state_reg <= (idx_reg + NCW'(1) == n_reg) ? S_SEL_END : S_SEL_RD;
                end
                S_SEL_END:
                begin
                    if (!best_found_reg)
                    begin
                        done_reg                 <= 1'b1;
                        result_reg.pair_sum      <= sum_reg[SUM_BITS-1:0];
                        result_reg.edge_overflow <= overflow_reg;
                        state_reg                <= S_IDLE;
                    end
                    else
                    begin
                        cur_key_reg <= best_key_reg;
                        cur_u_reg   <= ~best_key_reg[NW-1:0];
                        first_reg   <= 1'b0;
                        k_reg       <= '0;
                        state_reg   <= S_EDGE_RD;
                    end
                end
                S_EDGE_RD:
                begin
                    if (k_reg == edges_loaded_reg)
                    begin
                        idx_reg        <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= S_SEL_RD;
                    end
                    else
                    begin
                        state_reg <= S_EDGE_CHK;
                    end
                end
                S_EDGE_CHK:
                begin
                    k_reg     <= k_reg + EW'(1);
                    v_reg     <= edge_other;
                    state_reg <= edge_hit ? S_VW_CHK : S_EDGE_RD;
                end
                S_VW_CHK:
                begin
                    // neighbor already active when its key ranks above ours
                    if ({weight_q, ~v_reg} > cur_key_reg)
                    begin
                        x_reg     <= cur_u_reg;
                        state_reg <= S_FU_RD;
                    end
                    else
                    begin
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_FU_RD:
                begin
                    state_reg <= S_FU_CHK;
                end
                S_FU_CHK:
                begin
                    if (link_q == x_reg)
                    begin
                        ru_reg    <= x_reg;
                        x_reg     <= v_reg;
                        state_reg <= S_FV_RD;
                    end
                    else
                    begin
                        x_reg     <= link_q;
                        state_reg <= S_FU_RD;
                    end
                end
                S_FV_RD:
                begin
                    state_reg <= S_FV_CHK;
                end
                S_FV_CHK:
                begin
                    if (link_q == x_reg)
                    begin
                        rv_reg    <= x_reg;
                        state_reg <= (x_reg == ru_reg) ? S_EDGE_RD : S_SZ_A;
                    end
                    else
                    begin
                        x_reg     <= link_q;
                        state_reg <= S_FV_RD;
                    end
                end
                S_SZ_A:
                begin
                    state_reg <= S_SZ_B;
                end
                S_SZ_B:
                begin
                    sa_reg    <= size_q;
                    state_reg <= S_SZ_C;
                end
                S_SZ_C:
                begin
                    sb_reg    <= size_q;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // product lands next cycle; accumulate it on the edge read
                    state_reg <= S_EDGE_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_MUL2)
            begin
                sum_reg <= sum_reg;
            end
            if (state_reg == S_EDGE_RD && acc_pending_reg)
            begin
                sum_reg <= sum_reg + ACC_BITS'(prod_reg);
            end
        end
    end

    // mark the cycle in which the second product is valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pending_reg <= 1'b0;
        end
        else
        begin
            acc_pending_reg <= (state_reg == S_MUL2);
        end
    end

endmodule
